FILE: design/zrvlq_pkg.sv
// Package for the zero-run / VLQ coefficient decoder.
// Holds the parse phase codes, VLQ byte constants and the response type.
// No dependencies.
`default_nettype none

package zrvlq_pkg;

   // Parse phase codes
   localparam logic [1:0] PH_COUNT_LO = 2'd0;
   localparam logic [1:0] PH_COUNT_HI = 2'd1;
   localparam logic [1:0] PH_VALUES   = 2'd2;

   // VLQ byte layout: bit 7 marks the last byte, bits 6..0 carry a group
   localparam int unsigned VLQ_LAST_BIT   = 7;
   localparam int unsigned VLQ_GROUP_BITS = 7;

   // Saturation point of the group counter (weight 2^21 and up is lost mod 2^16)
   localparam logic [1:0] GROUP_SAT = 2'd3;

   // One decoded response
   typedef struct packed {
      logic signed [15:0] coeff_value;
      logic [15:0]        run_length;
      logic               is_zero_run;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/zero_run_vlq_decoder.sv
// Zero-run / VLQ coefficient decoder: one stream byte per request; depends on zrvlq_pkg.
// The response for the request byte that completes it is registered into the output queue.
// Throughput: one byte per cycle while req_stall is low; each accepted byte updates the parse state.
// A two-entry output queue stalls requests only when both entries are full.
// Reset (synchronous, active high) returns the parser to expect a count low byte
// of a zero run and empties the output queue.
`default_nettype none

module zero_run_vlq_decoder
   import zrvlq_pkg::*;
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [7:0]         req_in_byte,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic signed [15:0] rsp_coeff_value,
   output logic [15:0]        rsp_run_length,
   output logic               rsp_is_zero_run
);

   // Parse state
   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  count_lo_ff, count_lo_in;
   logic [15:0] values_left_ff, values_left_in;
   logic        run_is_zero_ff, run_is_zero_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  group_idx_ff, group_idx_in;

   // Output queue
   logic [1:0]  fill_ff, fill_in;
   rsp_type     head_ff, head_in;
   rsp_type     tail_ff, tail_in;

   logic        req_accept;
   logic        rsp_take;
   logic        res_valid;
   rsp_type     res;
   logic [15:0] count;
   logic [6:0]  grp;
   logic [15:0] grp_shifted;
   logic [15:0] acc_sum;

   assign req_stall  = (fill_ff == 2'd2);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (fill_ff != 2'd0);
   assign rsp_take   = rsp_valid && !rsp_stall;

   assign count = {req_in_byte, count_lo_ff};
   assign grp   = req_in_byte[VLQ_GROUP_BITS-1:0];

   // Weight the incoming 7-bit group by its position, modulo 2^16
   always_comb begin
      case (group_idx_ff)
         2'd0:    grp_shifted = {9'd0, grp};
         2'd1:    grp_shifted = {2'd0, grp, 7'd0};
         2'd2:    grp_shifted = {grp[1:0], 14'd0};
         default: grp_shifted = 16'd0;
      endcase
   end

   assign acc_sum = acc_ff + grp_shifted;

   // Parse one byte and compute the next state and any response
   always_comb begin
      phase_in       = phase_ff;
      count_lo_in    = count_lo_ff;
      values_left_in = values_left_ff;
      run_is_zero_in = run_is_zero_ff;
      acc_in         = acc_ff;
      group_idx_in   = group_idx_ff;
      res_valid      = 1'b0;
      res.coeff_value = acc_sum;
      res.run_length  = 16'd1;
      res.is_zero_run = 1'b0;

      if (req_accept) begin
         case (phase_ff)
            PH_COUNT_HI: begin
               run_is_zero_in = !run_is_zero_ff;
               phase_in       = PH_COUNT_LO;
               if (count != 16'd0) begin
                  if (!run_is_zero_ff) begin
                     // Count completes a zero run: one response for the whole run
                     res_valid       = 1'b1;
                     res.coeff_value = 16'sd0;
                     res.run_length  = count;
                     res.is_zero_run = 1'b1;
                  end else begin
                     values_left_in = count;
                     acc_in         = 16'd0;
                     group_idx_in   = 2'd0;
                     phase_in       = PH_VALUES;
                  end
               end
            end
            PH_VALUES: begin
               acc_in = acc_sum;
               if (!req_in_byte[VLQ_LAST_BIT]) begin
                  if (group_idx_ff != GROUP_SAT) begin
                     group_idx_in = group_idx_ff + 2'd1;
                  end
               end else begin
                  // Last byte of a value: emit it and move to the next value, or to the next count after the last value
                  res_valid      = 1'b1;
                  acc_in         = 16'd0;
                  group_idx_in   = 2'd0;
                  values_left_in = values_left_ff - 16'd1;
                  if (values_left_ff == 16'd1) begin
                     phase_in = PH_COUNT_LO;
                  end
               end
            end
            default: begin
               count_lo_in = req_in_byte;
               phase_in    = PH_COUNT_HI;
            end
         endcase
      end
   end

   // Output queue: head drives the response port, tail holds an overflow entry
   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      case (fill_ff)
         2'd0: begin
            if (res_valid) begin
               head_in = res;
               fill_in = 2'd1;
            end
         end
         2'd1: begin
            if (rsp_take && res_valid) begin
               head_in = res;
            end else if (rsp_take) begin
               fill_in = 2'd0;
            end else if (res_valid) begin
               tail_in = res;
               fill_in = 2'd2;
            end
         end
         default: begin
            if (rsp_take) begin
               head_in = tail_ff;
               fill_in = 2'd1;
            end
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_COUNT_LO;
         count_lo_ff    <= 8'd0;
         values_left_ff <= 16'd0;
         run_is_zero_ff <= 1'b0;
         acc_ff         <= 16'd0;
         group_idx_ff   <= 2'd0;
         fill_ff        <= 2'd0;
      end else begin
         phase_ff       <= phase_in;
         count_lo_ff    <= count_lo_in;
         values_left_ff <= values_left_in;
         run_is_zero_ff <= run_is_zero_in;
         acc_ff         <= acc_in;
         group_idx_ff   <= group_idx_in;
         fill_ff        <= fill_in;
      end
   end

   // Payload registers of the output queue
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_coeff_value = head_ff.coeff_value;
   assign rsp_run_length  = head_ff.run_length;
   assign rsp_is_zero_run = head_ff.is_zero_run;

endmodule

`default_nettype wire
